// ----- sv/nfcrp_pkg.sv -----
// ---------------------------------------------------------------------------
// nfcrp_pkg
// Shared types and constants for the NFC response frame parser: parse
// phases, frame status codes, register indexes and the beat structures.
// ---------------------------------------------------------------------------
package nfcrp_pkg;

    // Frame marker bytes and the minimum legal frame length.
    localparam logic [7:0] PREAMBLE_ZERO = 8'h00;
    localparam logic [7:0] START_CODE_FF = 8'hFF;
    localparam logic [7:0] MIN_FRAME_LEN = 8'd2;

    // Configuration register indexes and their reset values.
    localparam logic [7:0] CFG_PAYLOAD_CAPACITY = 8'd0;
    localparam logic [7:0] CFG_FRAME_ID         = 8'd1;
    localparam logic [7:0] CAPACITY_RESET       = 8'd64;
    localparam logic [7:0] FRAME_ID_RESET       = 8'd213;

    // Result beat kinds.
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_FINISH  = 1'b1;

    // Parse phases, one-hot.
    typedef enum logic [9:0] {
        PH_IDLE  = 10'b00_0000_0001,
        PH_PRE0  = 10'b00_0000_0010,
        PH_PRE1  = 10'b00_0000_0100,
        PH_START = 10'b00_0000_1000,
        PH_LEN   = 10'b00_0001_0000,
        PH_LCS   = 10'b00_0010_0000,
        PH_TFI   = 10'b00_0100_0000,
        PH_CODE  = 10'b00_1000_0000,
        PH_DATA  = 10'b01_0000_0000,
        PH_DCS   = 10'b10_0000_0000
    } t_phase;

    // Frame status codes.
    typedef enum logic [2:0] {
        ST_OK    = 3'd0,
        ST_START = 3'd1,
        ST_LSUM  = 3'd2,
        ST_SHORT = 3'd3,
        ST_ID    = 3'd4,
        ST_DSUM  = 3'd5,
        ST_OVER  = 3'd6,
        ST_EARLY = 3'd7
    } t_status;

    // One input beat.
    typedef struct packed {
        logic [7:0] rx_byte;
        logic       read_start;
        logic       read_end;
    } t_in_beat;

    // One result beat.
    typedef struct packed {
        logic       item_kind;
        logic [7:0] payload_byte;
        t_status    frame_status;
        logic [7:0] payload_count;
        logic [7:0] response_code;
    } t_result;

endpackage

// ----- sv/nfcrp_parse_core.sv -----
// ---------------------------------------------------------------------------
// nfcrp_parse_core
// Frame parsing state and the combinational logic that turns one registered
// input beat into the next state and at most one result beat.
// ---------------------------------------------------------------------------
module nfcrp_parse_core
    import nfcrp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_advance,
    input  t_in_beat   i_beat,
    input  logic [7:0] i_capacity,
    input  logic [7:0] i_frame_id,
    output logic       o_res_valid,
    output t_result    o_res
);

    t_phase     r_phase,  n_phase;
    logic [7:0] r_len,    n_len;
    logic [7:0] r_rem,    n_rem;
    logic [7:0] r_sum,    n_sum;
    logic [7:0] r_code,   n_code;
    logic [7:0] r_count,  n_count;
    logic       busy;
    logic [7:0] payload_len;

    assign busy        = (r_phase != PH_IDLE);
    assign payload_len = r_len - MIN_FRAME_LEN;

    // Next state and result for the beat held in the input register.
    always_comb begin
        n_phase     = r_phase;
        n_len       = r_len;
        n_rem       = r_rem;
        n_sum       = r_sum;
        n_code      = r_code;
        n_count     = r_count;
        o_res_valid = 1'b0;
        o_res       = '{item_kind: KIND_FINISH, payload_byte: 8'd0,
                        frame_status: ST_OK, payload_count: r_count,
                        response_code: r_code};

        if (i_beat.read_end) begin
            if (busy) begin
                o_res_valid        = 1'b1;
                o_res.frame_status = ST_EARLY;
                n_phase            = PH_IDLE;
            end
        end else if (i_beat.read_start) begin
            // A new read aborts any frame still open.
            if (busy) begin
                o_res_valid        = 1'b1;
                o_res.frame_status = ST_EARLY;
            end
            n_phase = PH_PRE0;
            n_len   = 8'd0;
            n_rem   = 8'd0;
            n_sum   = 8'd0;
            n_code  = 8'd0;
            n_count = 8'd0;
        end else begin
            unique case (r_phase)
                PH_IDLE: begin
                end
                PH_PRE0: begin
                    if (i_beat.rx_byte != PREAMBLE_ZERO) begin
                        o_res_valid        = 1'b1;
                        o_res.frame_status = ST_START;
                        n_phase            = PH_IDLE;
                    end else begin
                        n_phase = PH_PRE1;
                    end
                end
                PH_PRE1: begin
                    if (i_beat.rx_byte != PREAMBLE_ZERO) begin
                        o_res_valid        = 1'b1;
                        o_res.frame_status = ST_START;
                        n_phase            = PH_IDLE;
                    end else begin
                        n_phase = PH_START;
                    end
                end
                PH_START: begin
                    if (i_beat.rx_byte != START_CODE_FF) begin
                        o_res_valid        = 1'b1;
                        o_res.frame_status = ST_START;
                        n_phase            = PH_IDLE;
                    end else begin
                        n_phase = PH_LEN;
                    end
                end
                PH_LEN: begin
                    n_len   = i_beat.rx_byte;
                    n_phase = PH_LCS;
                end
                PH_LCS: begin
                    if ((r_len + i_beat.rx_byte) != 8'd0) begin
                        o_res_valid        = 1'b1;
                        o_res.frame_status = ST_LSUM;
                        n_phase            = PH_IDLE;
                    end else if (r_len < MIN_FRAME_LEN) begin
                        o_res_valid        = 1'b1;
                        o_res.frame_status = ST_SHORT;
                        n_phase            = PH_IDLE;
                    end else begin
                        n_phase = PH_TFI;
                    end
                end
                PH_TFI: begin
                    if (i_beat.rx_byte != i_frame_id) begin
                        o_res_valid        = 1'b1;
                        o_res.frame_status = ST_ID;
                        n_phase            = PH_IDLE;
                    end else begin
                        n_sum   = i_beat.rx_byte;
                        n_phase = PH_CODE;
                    end
                end
                PH_CODE: begin
                    n_code = i_beat.rx_byte;
                    n_sum  = r_sum + i_beat.rx_byte;
                    n_rem  = payload_len;
                    if (payload_len > i_capacity) begin
                        o_res_valid         = 1'b1;
                        o_res.frame_status  = ST_OVER;
                        o_res.response_code = i_beat.rx_byte;
                        n_phase             = PH_IDLE;
                    end else if (payload_len != 8'd0) begin
                        n_phase = PH_DATA;
                    end else begin
                        n_phase = PH_DCS;
                    end
                end
                PH_DATA: begin
                    n_sum   = r_sum + i_beat.rx_byte;
                    n_count = r_count + 8'd1;
                    n_rem   = r_rem - 8'd1;
                    if (r_rem == 8'd1) begin
                        n_phase = PH_DCS;
                    end
                    o_res_valid         = 1'b1;
                    o_res.item_kind     = KIND_PAYLOAD;
                    o_res.payload_byte  = i_beat.rx_byte;
                    o_res.payload_count = r_count + 8'd1;
                end
                PH_DCS: begin
                    o_res_valid = 1'b1;
                    if ((r_sum + i_beat.rx_byte) != 8'd0) begin
                        o_res.frame_status = ST_DSUM;
                    end else begin
                        o_res.frame_status = ST_OK;
                    end
                    n_phase = PH_IDLE;
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end
    end

    // State registers, updated only when the beat moves on.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_len   <= 8'd0;
            r_rem   <= 8'd0;
            r_sum   <= 8'd0;
            r_code  <= 8'd0;
            r_count <= 8'd0;
        end else if (i_advance) begin
            r_phase <= n_phase;
            r_len   <= n_len;
            r_rem   <= n_rem;
            r_sum   <= n_sum;
            r_code  <= n_code;
            r_count <= n_count;
        end
    end

    // A result only ever comes out of an open frame.
    a_result_needs_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> busy)
        else $error("result produced while parser idle");

    // The payload phase always has bytes left to take.
    a_data_has_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DATA) |-> (r_rem != 8'd0))
        else $error("payload phase with no bytes remaining");

    // Delivered plus remaining bytes always add up to the frame payload.
    a_count_balance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_phase == PH_DATA) || (r_phase == PH_DCS))
            |-> (8'(r_count + r_rem) == payload_len))
        else $error("payload count and remaining count disagree");

endmodule

// ----- sv/nfcrp_out_stage.sv -----
// ---------------------------------------------------------------------------
// nfcrp_out_stage
// Result register between the parsing logic and the output channel. It
// takes a new beat in the same cycle that the held beat is taken.
// ---------------------------------------------------------------------------
module nfcrp_out_stage
    import nfcrp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_res,
    input  logic    i_ready,
    output logic    o_free,
    output logic    o_valid,
    output t_result o_res
);

    logic    r_valid;
    t_result r_res;

    // The slot is free when empty or when its beat leaves this cycle.
    assign o_free  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    // Valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    // Payload register.
    always_ff @(posedge i_clk) begin
        if (o_free && i_load) begin
            r_res <= i_res;
        end
    end

endmodule

// ----- sv/nfc_response_frame_parser.sv -----
// ---------------------------------------------------------------------------
// nfc_response_frame_parser
// Parses the bytes of one NFC controller response read, passes payload
// bytes on and reports the frame status at the end of each frame.
//
//   Channel   Direction  Handshake                   Payload
//   -------   ---------  --------------------------  ------------------------
//   input     in         i_in_valid / o_in_ready     rx_byte, read_start/end
//   output    out        o_out_valid / i_out_ready   kind, byte, status, count,
//                                                    response code
//   config    in         i_cfg_valid / o_cfg_ready   index, data
//
// One beat per cycle is taken while the output is not stalled. A beat is
// held in the input register, then its result (if any) lands in the result
// register once that register is free, which raises output valid. A stalled
// output register holds the input register, which then stops taking beats.
// Reset clears the parse state to idle and loads the register defaults;
// config writes are always ready.
// ---------------------------------------------------------------------------
module nfc_response_frame_parser
    import nfcrp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    // Input beats.
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_rx_byte,
    input  logic       i_read_start,
    input  logic       i_read_end,
    // Result beats.
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic       o_item_kind,
    output logic [7:0] o_payload_byte,
    output logic [2:0] o_frame_status,
    output logic [7:0] o_payload_count,
    output logic [7:0] o_response_code,
    // Configuration writes.
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [7:0] i_cfg_index,
    input  logic [7:0] i_cfg_data
);

    logic       r_capacity;
    logic [7:0] r_cap;
    logic [7:0] r_frame_id;
    logic       r_in_valid;
    t_in_beat   r_in_beat;
    logic       advance;
    logic       out_free;
    logic       res_valid;
    t_result    res;
    t_result    out_res;

    assign o_cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap      <= CAPACITY_RESET;
            r_frame_id <= FRAME_ID_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_PAYLOAD_CAPACITY: r_cap      <= i_cfg_data;
                CFG_FRAME_ID:         r_frame_id <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Marks that the capacity register has been written since reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= 1'b0;
        end else if (i_cfg_valid && (i_cfg_index == CFG_PAYLOAD_CAPACITY)) begin
            r_capacity <= 1'b1;
        end
    end

    // The held beat moves on once the result register can take its result.
    assign advance    = r_in_valid && out_free;
    assign o_in_ready = !r_in_valid || advance;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_beat <= '{rx_byte: i_rx_byte, read_start: i_read_start,
                           read_end: i_read_end};
        end
    end

    nfcrp_parse_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_advance   (advance),
        .i_beat      (r_in_beat),
        .i_capacity  (r_cap),
        .i_frame_id  (r_frame_id),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    nfcrp_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (advance && res_valid),
        .i_res   (res),
        .i_ready (i_out_ready),
        .o_free  (out_free),
        .o_valid (o_out_valid),
        .o_res   (out_res)
    );

    assign o_item_kind     = out_res.item_kind;
    assign o_payload_byte  = out_res.payload_byte;
    assign o_frame_status  = out_res.frame_status;
    assign o_payload_count = out_res.payload_count;
    assign o_response_code = out_res.response_code;

    // After any capacity write the overflow check uses the written value.
    a_cap_written: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_valid && (i_cfg_index == CFG_PAYLOAD_CAPACITY))
            |=> (r_capacity && (r_cap == $past(i_cfg_data))))
        else $error("capacity write not taken");

    // A beat leaves the input register only into a free result register.
    a_advance_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |-> (!o_out_valid || i_out_ready))
        else $error("beat processed while result register blocked");

    // A held input beat with a stalled output stays put.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && o_out_valid && !i_out_ready) |=> r_in_valid)
        else $error("input beat lost during output stall");

endmodule
